FILE: sv/xcfr_pkg.sv
`default_nettype none

package xcfr_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'hBB;
  localparam logic [15:0] ADDR_ONE    = 16'h0001;

  typedef enum logic [2:0] {
    STAT_HUNTING  = 3'd0,
    STAT_IN_FRAME = 3'd1,
    STAT_ACCEPTED = 3'd2,
    STAT_CHK_FAIL = 3'd3,
    STAT_ADDR_BAD = 3'd4,
    STAT_TOO_LONG = 3'd5
  } status_t;

  typedef enum logic {
    KIND_STATUS  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  localparam logic [0:0] CFG_ADDRESS_MODE   = 1'd0;
  localparam logic [0:0] CFG_DEVICE_ADDRESS = 1'd1;

  typedef struct packed {
    logic       address_mode;
    logic [7:0] device_address;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/xcfr_if.sv
`default_nettype none

interface xcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] status;
  logic [7:0] source_address;
  logic [4:0] payload_length;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output kind, output status, output source_address,
                  output payload_length, output payload_byte, output last, input ready);
  modport sink (input valid, input kind, input status, input source_address,
                input payload_length, input payload_byte, input last, output ready);
endinterface

interface xcfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/xcfr_ram.sv
`default_nettype none

module xcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/xcfr_parser.sv
`default_nettype none

module xcfr_parser
  import xcfr_pkg::*;
#(
  parameter int LEN_LIMIT = 26,
  parameter int ADDR_W    = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  xcfr_in_if.sink                in_ch,
  xcfr_out_if.source             out_ch,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output logic [7:0]             ram_wdata,
  output logic                   ram_re,
  output logic [ADDR_W-1:0]      ram_raddr,
  input  wire logic [7:0]        ram_rdata
);

  localparam int POS_W = $clog2(LEN_LIMIT + 6);
  localparam int LEN_W = $clog2(LEN_LIMIT + 1);
  localparam logic [POS_W-1:0] P_HUNT = POS_W'(0);
  localparam logic [POS_W-1:0] P_SYNC = POS_W'(1);
  localparam logic [POS_W-1:0] P_SRC  = POS_W'(2);
  localparam logic [POS_W-1:0] P_DST  = POS_W'(3);
  localparam logic [POS_W-1:0] P_LEN  = POS_W'(4);
  localparam logic [POS_W-1:0] P_BODY = POS_W'(5);

  typedef enum logic [2:0] {
    ST_RX   = 3'b001,
    ST_READ = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       src_r, src_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  logic [7:0]       out_src_r, out_src_nxt;
  logic [4:0]       out_len_r, out_len_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free;
  logic             in_acc;
  logic [7:0]       b;
  status_t          stat;
  logic             frame_ok;
  logic             addr_match;
  logic [7:0]       src_v;
  logic             in_body;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_RX) && out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign b            = in_ch.rx_byte;
  assign in_body      = {1'b0, pos_r} <= ((POS_W + 1)'(len_r) + (POS_W + 1)'(4));

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.source_address = out_src_r;
  assign out_ch.payload_length = out_len_r;
  assign out_ch.payload_byte   = out_byte_r;
  assign out_ch.last           = out_last_r;

  always_comb begin
    if (cfg.address_mode) begin
      addr_match = (b == cfg.device_address);
    end else begin
      addr_match = (cfg.device_address < 8'd16) &&
                   ({src_r, b} == (ADDR_ONE << cfg.device_address[3:0]));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    xor_nxt        = xor_r;
    src_nxt        = src_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_src_nxt    = out_src_r;
    out_len_nxt    = out_len_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    stat           = STAT_IN_FRAME;
    frame_ok       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = ADDR_W'(pos_r - P_BODY);
    ram_wdata      = b;
    ram_re         = 1'b0;
    ram_raddr      = idx_r[ADDR_W-1:0];
    src_v          = (pos_r == P_HUNT || pos_r == P_SYNC) ? 8'd0 :
                     (pos_r == P_SRC) ? b : src_r;

    unique case (state_r)
      ST_RX: begin
        if (in_acc) begin
          case (pos_r)
            P_HUNT: begin
              if (b == SYNC_FIRST) begin
                pos_nxt = P_SYNC;
              end else begin
                stat = STAT_HUNTING;
              end
            end
            P_SYNC: begin
              if (b == SYNC_SECOND) begin
                pos_nxt = P_SRC;
              end else begin
                pos_nxt = P_HUNT;
                stat    = STAT_HUNTING;
              end
            end
            P_SRC: begin
              src_nxt = b;
              xor_nxt = b;
              pos_nxt = P_DST;
            end
            P_DST: begin
              xor_nxt = xor_r ^ b;
              if (addr_match) begin
                pos_nxt = P_LEN;
              end else begin
                pos_nxt = P_HUNT;
                stat    = STAT_ADDR_BAD;
              end
            end
            P_LEN: begin
              xor_nxt = xor_r ^ b;
              len_nxt = LEN_W'(b);
              if (b > 8'(LEN_LIMIT)) begin
                pos_nxt = P_HUNT;
                stat    = STAT_TOO_LONG;
              end else begin
                pos_nxt = P_BODY;
              end
            end
            default: begin
              if (in_body) begin
                ram_we  = 1'b1;
                xor_nxt = xor_r ^ b;
                pos_nxt = pos_r + POS_W'(1);
              end else begin
                pos_nxt = P_HUNT;
                if (b == xor_r) begin
                  stat     = STAT_ACCEPTED;
                  frame_ok = 1'b1;
                end else begin
                  stat = STAT_CHK_FAIL;
                end
              end
            end
          endcase
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_STATUS;
          out_status_nxt = stat;
          out_src_nxt    = src_v;
          out_len_nxt    = frame_ok ? 5'(len_r) : 5'd0;
          out_byte_nxt   = 8'd0;
          out_last_nxt   = !(frame_ok && len_r != '0);
          if (frame_ok && len_r != '0) begin
            state_nxt = ST_READ;
            idx_nxt   = '0;
          end
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_PAYLOAD;
          out_status_nxt = STAT_ACCEPTED;
          out_src_nxt    = src_r;
          out_len_nxt    = 5'(len_r);
          out_byte_nxt   = ram_rdata;
          out_last_nxt   = (idx_r + LEN_W'(1)) == len_r;
          if ((idx_r + LEN_W'(1)) == len_r) begin
            state_nxt = ST_RX;
          end else begin
            idx_nxt   = idx_r + LEN_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_RX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RX;
      pos_r       <= P_HUNT;
      xor_r       <= 8'd0;
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      xor_r       <= xor_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_src_r    <= out_src_nxt;
    out_len_r    <= out_len_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_ok && len_r != '0) |=> (state_r == ST_READ && idx_r == '0))
    else $error("accepted frame did not start its payload burst");

  a_read_then_send: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_SEND))
    else $error("store read not followed by a send cycle");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RX) |-> (idx_r < len_r))
    else $error("burst index beyond the frame length");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} <= (POS_W + 1)'(LEN_LIMIT + 5))
    else $error("byte position beyond the longest frame");

endmodule

`default_nettype wire

FILE: sv/xor_checked_frame_receiver.sv
// Frame receiver for a byte-serial link with an XOR checksum.
// Bytes enter on in_ch, one item each, and frames of the form
// AA BB source destination length payload checksum are picked out of them.
// Every byte gives one status item on out_ch (kind 0, last set), except the
// checksum byte of an accepted frame, which gives a status item followed by
// one payload item per payload byte, the final one carrying last.
// Registers are written through cfg_ch, which is always ready: index 0 is the
// address mode, index 1 the device address. Write them only while idle.
// A byte is accepted whenever the output register is empty or being emptied,
// so ordinary bytes flow at one per cycle. Its status item appears in the
// cycle after acceptance. Payload bytes are read back from the frame store
// through its registered read port; each payload byte passes a read state
// and then a send state, and no input is accepted during the burst.
// When out_ch stalls, the pending item is held and in_ch stops accepting.
// Synchronous reset returns to hunting for the first sync byte with the
// address mode set to 1 and the device address cleared; the frame store
// needs no clearing as only bytes of the current frame are ever read.
`default_nettype none

module xor_checked_frame_receiver
  import xcfr_pkg::*;
#(
  parameter int FRAME_BYTES = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  xcfr_in_if.sink    in_ch,
  xcfr_out_if.source out_ch,
  xcfr_cfg_if.sink   cfg_ch
);

  localparam int LEN_LIMIT = (FRAME_BYTES - 6 < 26) ? FRAME_BYTES - 6 : 26;
  localparam int ADDR_W    = (LEN_LIMIT > 1) ? $clog2(LEN_LIMIT) : 1;

  cfg_t              cfg_r;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address_mode   <= 1'b1;
      cfg_r.device_address <= 8'd0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ADDRESS_MODE:   cfg_r.address_mode   <= cfg_ch.data[0];
        CFG_DEVICE_ADDRESS: cfg_r.device_address <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  xcfr_parser #(
    .LEN_LIMIT (LEN_LIMIT),
    .ADDR_W    (ADDR_W)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  xcfr_ram #(
    .WIDTH (8),
    .DEPTH (LEN_LIMIT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: sim/xcfr_checker.sv
`timescale 1ns / 1ps

module xcfr_checker
  import xcfr_pkg::*;
#(
  parameter int FRAME_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  xcfr_in_if          in_ch,
  xcfr_out_if         out_ch,
  xcfr_cfg_if         cfg_ch,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned results_seen,
  output int unsigned frames_accepted
);

  localparam int LEN_MAX = (FRAME_BYTES - 6 < 26) ? FRAME_BYTES - 6 : 26;

  typedef struct packed {
    kind_t      kind;
    status_t    status;
    logic [7:0] src;
    logic [4:0] plen;
    logic [7:0] pbyte;
    logic       last;
  } frame_result_t;

  logic          addr_mode;
  logic [7:0]    dev_addr;
  logic [5:0]    pos;
  logic [7:0]    frame_bytes [64];
  logic [7:0]    chk_acc;
  logic [7:0]    flen;
  frame_result_t due_results [$];
  frame_result_t want;
  int unsigned   n_bad = 0;
  int unsigned   n_results = 0;
  int unsigned   n_frames = 0;

  function automatic frame_result_t make_result(kind_t k, status_t s, logic [7:0] src,
                                                logic [4:0] plen, logic [7:0] pbyte,
                                                logic last);
    frame_result_t r;
    r.kind = k;
    r.status = s;
    r.src = src;
    r.plen = plen;
    r.pbyte = pbyte;
    r.last = last;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH %s", msg);
    n_bad++;
  endtask

  // Advances the frame tracker by one received byte and queues the items
  // that the byte should produce.
  task automatic track_frame_byte(input logic [7:0] b);
    status_t     st;
    logic [7:0]  src;
    logic        take;
    logic        hit;
    logic [15:0] word;
    logic [4:0]  n;
    st = STAT_IN_FRAME;
    src = '0;
    take = 1'b0;
    if (pos >= 2) src = (pos == 2) ? b : frame_bytes[2];
    if (pos == 0) begin
      if (b == SYNC_FIRST) begin
        frame_bytes[0] = b;
        pos = 6'd1;
      end else begin
        st = STAT_HUNTING;
      end
    end else if (pos == 1) begin
      if (b == SYNC_SECOND) begin
        frame_bytes[1] = b;
        pos = 6'd2;
      end else begin
        pos = 6'd0;
        st = STAT_HUNTING;
      end
    end else if (pos == 2) begin
      frame_bytes[2] = b;
      chk_acc = b;
      pos = 6'd3;
    end else if (pos == 3) begin
      frame_bytes[3] = b;
      chk_acc ^= b;
      word = {frame_bytes[2], b};
      if (addr_mode) hit = (b == dev_addr);
      else hit = (dev_addr < 16) && (word == (ADDR_ONE << dev_addr[3:0]));
      if (hit) begin
        pos = 6'd4;
      end else begin
        pos = 6'd0;
        st = STAT_ADDR_BAD;
      end
    end else if (pos == 4) begin
      frame_bytes[4] = b;
      flen = b;
      chk_acc ^= b;
      if (int'(b) > LEN_MAX) begin
        pos = 6'd0;
        st = STAT_TOO_LONG;
      end else begin
        pos = 6'd5;
      end
    end else if (int'(pos) <= int'(flen) + 4) begin
      frame_bytes[pos] = b;
      chk_acc ^= b;
      pos = pos + 6'd1;
    end else begin
      frame_bytes[pos] = b;
      if (b == chk_acc) begin
        take = 1'b1;
        st = STAT_ACCEPTED;
      end else begin
        st = STAT_CHK_FAIL;
      end
      pos = 6'd0;
    end

    if (!take) begin
      due_results.push_back(make_result(KIND_STATUS, st, src, '0, '0, 1'b1));
    end else begin
      n = flen[4:0];
      n_frames++;
      due_results.push_back(make_result(KIND_STATUS, STAT_ACCEPTED, src, n, '0, n == 0));
      for (int i = 0; i < int'(n); i++)
        due_results.push_back(make_result(KIND_PAYLOAD, STAT_ACCEPTED, src, n,
                                          frame_bytes[5 + i], i == int'(n) - 1));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      addr_mode = 1'b1;
      dev_addr = '0;
      pos = '0;
      chk_acc = '0;
      flen = '0;
      due_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("item %0d arrived with nothing awaited", n_results));
        end else begin
          want = due_results.pop_front();
          if (out_ch.kind !== want.kind)
            report_mismatch($sformatf("item %0d: kind %0d, wanted %0d",
                                      n_results, out_ch.kind, want.kind));
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("item %0d: status %0d, wanted %0d",
                                      n_results, out_ch.status, want.status));
          if (out_ch.source_address !== want.src)
            report_mismatch($sformatf("item %0d: source_address %0h, wanted %0h",
                                      n_results, out_ch.source_address, want.src));
          if (out_ch.payload_length !== want.plen)
            report_mismatch($sformatf("item %0d: payload_length %0d, wanted %0d",
                                      n_results, out_ch.payload_length, want.plen));
          if (out_ch.payload_byte !== want.pbyte)
            report_mismatch($sformatf("item %0d: payload_byte %0h, wanted %0h",
                                      n_results, out_ch.payload_byte, want.pbyte));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("item %0d: last %0d, wanted %0d",
                                      n_results, out_ch.last, want.last));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_ADDRESS_MODE) addr_mode = cfg_ch.data[0];
        else if (cfg_ch.index == CFG_DEVICE_ADDRESS) dev_addr = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) track_frame_byte(in_ch.rx_byte);
    end
    mismatches <= n_bad;
    outstanding <= due_results.size();
    results_seen <= n_results;
    frames_accepted <= n_frames;
  end

endmodule

FILE: sim/xor_checked_frame_receiver_tb.sv
`timescale 1ns / 1ps

module xor_checked_frame_receiver_tb
  import xcfr_pkg::*;
();

  localparam int FRAME_BYTES = 32;
  localparam int LEN_MAX     = (FRAME_BYTES - 6 < 26) ? FRAME_BYTES - 6 : 26;
  localparam int PHASE_BYTES = 28;
  localparam int LONG_HOLD   = 80;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {
    FAULT_NONE,
    FAULT_CHECKSUM,
    FAULT_ADDRESS,
    FAULT_LENGTH,
    FAULT_SYNC
  } frame_fault_t;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned frames_accepted;
  bit          steady = 1'b0;
  bit          hold_armed = 1'b0;
  logic        cur_mode = 1'b1;
  logic [7:0]  cur_addr = '0;

  xcfr_in_if  in_ch ();
  xcfr_out_if out_ch ();
  xcfr_cfg_if cfg_ch ();

  xor_checked_frame_receiver #(.FRAME_BYTES(FRAME_BYTES)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  xcfr_checker #(.FRAME_BYTES(FRAME_BYTES)) frame_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_seen    (results_seen),
    .frames_accepted (frames_accepted)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input frame_fault_t fault);
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] chk;
    logic [7:0] pb;
    logic [7:0] bad;
    send_byte(SYNC_FIRST);
    if (fault == FAULT_SYNC) begin
      do bad = 8'($urandom); while (bad == SYNC_SECOND);
      send_byte(bad);
      return;
    end
    send_byte(SYNC_SECOND);
    if (!cur_mode && cur_addr < 16) begin
      {src, dst} = ADDR_ONE << cur_addr[3:0];
    end else begin
      src = 8'($urandom);
      dst = cur_mode ? cur_addr : 8'($urandom);
    end
    if (fault == FAULT_ADDRESS) begin
      if (cur_mode) dst ^= 8'($urandom_range(1, 255));
      else {src, dst} = {src, dst} ^ 16'($urandom_range(1, 65535));
    end
    send_byte(src);
    send_byte(dst);
    if (fault == FAULT_ADDRESS) return;
    if (fault == FAULT_LENGTH) begin
      send_byte(8'($urandom_range(LEN_MAX + 1, 255)));
      return;
    end
    chk = src ^ dst ^ 8'(len);
    send_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      pb = 8'($urandom);
      chk ^= pb;
      send_byte(pb);
    end
    if (fault == FAULT_CHECKSUM) chk ^= 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  task automatic random_phase(input int budget);
    int           stop_at;
    int           pick;
    int           len;
    int           r;
    frame_fault_t fault;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      steady = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, 9);
      len = (r == 0) ? LEN_MAX : (r == 1) ? $urandom_range(0, LEN_MAX) : $urandom_range(0, 6);
      if (pick < 60) fault = FAULT_NONE;
      else if (pick < 70) fault = FAULT_CHECKSUM;
      else if (pick < 78) fault = FAULT_ADDRESS;
      else if (pick < 85) fault = FAULT_LENGTH;
      else fault = FAULT_SYNC;
      if (pick >= 90) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      else send_frame(len, fault);
    end
    steady = 1'b0;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [7:0] addr);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_ADDRESS_MODE;
    cfg_ch.data <= {7'd0, mode};
    @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
    cfg_ch.index <= CFG_DEVICE_ADDRESS;
    cfg_ch.data <= addr;
    @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_mode = mode;
    cur_addr = addr;
    settings_used++;
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_ch.ready <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
      end
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_ADDRESS_MODE;
    cfg_ch.data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // The reset settings are in force here: address mode 1, address 0.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_frame(0, FAULT_NONE);
    send_frame(1, FAULT_CHECKSUM);
    send_frame(2, FAULT_ADDRESS);
    send_frame(0, FAULT_LENGTH);
    send_frame(1, FAULT_SYNC);
    random_phase(PHASE_BYTES);
    wait_idle();

    for (int k = 0; k < 8; k++) begin
      case (k)
        0: set_config(1'b0, 8'd0);
        1: set_config(1'b0, 8'd15);
        2: set_config(1'b0, 8'd255);
        3: set_config(1'b1, 8'd255);
        4: set_config(1'b1, 8'($urandom));
        5: set_config(1'b0, 8'($urandom_range(1, 14)));
        6: set_config(1'b0, 8'd16);
        default: set_config(1'b1, 8'd0);
      endcase
      if (k == 1) hold_armed = 1'b1;
      random_phase(PHASE_BYTES);
      wait_idle();
    end

    $display("Sent %0d bytes under %0d register settings;", bytes_sent, settings_used + 1);
    $display("%0d output items checked, %0d frames accepted.", results_seen, frames_accepted);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/xcfr_pkg.sv
sv/xcfr_if.sv
sv/xcfr_ram.sv
sv/xcfr_parser.sv
sv/xor_checked_frame_receiver.sv
sim/xcfr_checker.sv
sim/xor_checked_frame_receiver_tb.sv
